>>> rtl/ptq_pkg.sv
package ptq_pkg;

  // Request codes carried on req_type.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_PURGE  = 2'd3;

  // One queued transaction as held in a cell.
  typedef struct packed {
    logic        valid;
    logic [1:0]  prio;
    logic [7:0]  event_code;
    logic [15:0] handle;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } entry_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_PURGE,
    CELL_COMPACT
  } cell_op_t;

  // Broadcast control for the whole chain: the operation and the request item.
  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_ctrl_t;

endpackage

>>> rtl/priority_transaction_queue.sv
// Priority transaction queue. Holds up to DEPTH waiting transactions in a chain
// of cells kept in priority order (0 urgent first), first come first served
// within a level, and tracks how many dispatched transactions are running
// against the max_active limit (reset value 1, to be written on the cfg port
// only while idle; the block does not enforce this). One request is worked
// on at a time: an add or start updates the chain, and a start or finish the
// active count, in the cycle it is accepted; its result is loaded into the
// output register once that register is free. A purge lowers the active count
// and clears matching cells in its accept cycle, then compacts the chain,
// moving each hole one cell toward the tail per cycle. The next request is
// accepted while a finished result still waits in the output register; a
// request that finishes while the output register is still full waits for
// it. The cell valid bits are cleared by reset, so no clearing pass is needed.
module priority_transaction_queue #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write channel (max_active).
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [3:0]                   cfg_data,
  // Request channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic [7:0]                   event_code,
  input  logic [15:0]                  payload_handle,
  input  logic [1:0]                   priority_req,
  input  logic [63:0]                  node_addr_hi,
  input  logic [63:0]                  node_addr_lo,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         accepted,
  output logic                         dispatched,
  output logic [7:0]                   out_event_code,
  output logic [15:0]                  out_payload_handle,
  output logic [3:0]                   slots_left,
  output logic [$clog2(DEPTH+1)-1:0]   queue_count
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_COMPACT = 3'b010,
    S_FINISH  = 3'b100
  } state_t;

  typedef struct packed {
    logic       accepted;
    logic       dispatched;
    logic [7:0] event_code;
    logic [15:0] handle;
    logic [3:0] slots;
  } pend_t;

  state_t              state;
  state_t              state_next;
  logic [3:0]          max_active;
  logic [3:0]          active_count;
  logic [3:0]          active_count_next;
  pend_t               pend;
  pend_t               pend_next;
  ptq_pkg::cell_ctrl_t ctrl;

  ptq_pkg::entry_t     cells [DEPTH];
  ptq_pkg::entry_t     lefts [DEPTH];
  ptq_pkg::entry_t     rights [DEPTH];
  logic [DEPTH-1:0]    marks;
  logic [DEPTH-1:0]    left_marks;
  logic [DEPTH-1:0]    bubbles;
  logic [DEPTH-1:0]    valids;

  logic                accept;
  logic                full;
  logic                empty;
  logic                below_limit;
  logic                can_pop;
  logic                busy;
  logic                out_load;
  logic [DEPTH+1:0]    vx;
  logic [CW-1:0]       count_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_active <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      max_active <= cfg_data;
    end
  end

  // The chain is always compact outside a purge, so the last and first cells
  // tell whether the queue is full or empty.
  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign full        = valids[DEPTH-1];
  assign empty       = !valids[0];
  assign below_limit = (active_count < max_active);
  assign can_pop     = below_limit && !empty;
  assign busy        = |bubbles;

  // Chain of cells. Cell 0 sees a permanently valid, unmarked left neighbor;
  // the last cell sees an empty right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_comb begin
        lefts[i]       = '0;
        lefts[i].valid = 1'b1;
      end
      assign left_marks[i] = 1'b0;
    end else begin : g_body
      assign lefts[i]      = cells[i-1];
      assign left_marks[i] = marks[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rights[i] = '0;
    end else begin : g_inner
      assign rights[i] = cells[i+1];
    end

    ptq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (lefts[i]),
      .left_mark (left_marks[i]),
      .right     (rights[i]),
      .cur       (cells[i]),
      .mark      (marks[i]),
      .bubble    (bubbles[i])
    );
    assign valids[i] = cells[i].valid;
  end

  // Broadcast control for the chain.
  always_comb begin
    ctrl.item.valid      = 1'b1;
    ctrl.item.prio       = priority_req;
    ctrl.item.event_code = event_code;
    ctrl.item.handle     = payload_handle;
    ctrl.item.addr_hi    = node_addr_hi;
    ctrl.item.addr_lo    = node_addr_lo;
    ctrl.op              = ptq_pkg::CELL_HOLD;
    if (state == S_COMPACT) begin
      ctrl.op = ptq_pkg::CELL_COMPACT;
    end else if (accept) begin
      case (req_type)
        ptq_pkg::REQ_ADD:    ctrl.op = full ? ptq_pkg::CELL_HOLD : ptq_pkg::CELL_INSERT;
        ptq_pkg::REQ_START:  ctrl.op = can_pop ? ptq_pkg::CELL_POP : ptq_pkg::CELL_HOLD;
        ptq_pkg::REQ_PURGE:  ctrl.op = ptq_pkg::CELL_PURGE;
        default:             ctrl.op = ptq_pkg::CELL_HOLD;
      endcase
    end
  end

  // Per-request result fields other than the queue count, and the active count.
  always_comb begin
    pend_next         = pend;
    active_count_next = active_count;
    if (accept) begin
      pend_next = '0;
      case (req_type)
        ptq_pkg::REQ_ADD: begin
          pend_next.accepted = !full;
        end
        ptq_pkg::REQ_START: begin
          if (can_pop) begin
            pend_next.dispatched = 1'b1;
            pend_next.event_code = cells[0].event_code;
            pend_next.handle     = cells[0].handle;
            pend_next.slots      = max_active - active_count - 4'd1;
            active_count_next    = active_count + 4'd1;
          end
        end
        default: begin
          // Finish, and finish with purge of a node's entries.
          if (active_count != 4'd0) begin
            active_count_next = active_count - 4'd1;
          end
        end
      endcase
    end
  end

  // Queue count from the thermometer of valid bits: the single place where a
  // valid cell is followed by an empty one gives the count.
  always_comb begin
    vx              = '0;
    vx[0]           = 1'b1;
    vx[DEPTH:1]     = valids;
    count_now       = '0;
    for (int i = 0; i <= DEPTH; i++) begin
      if (vx[i] && !vx[i+1]) begin
        count_now = count_now | CW'(i);
      end
    end
  end

  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req_type == ptq_pkg::REQ_PURGE) ? S_COMPACT : S_FINISH;
        end
      end
      S_COMPACT: begin
        if (!busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_count <= 4'd0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      active_count <= active_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (out_load) begin
      accepted           <= pend.accepted;
      dispatched         <= pend.dispatched;
      out_event_code     <= pend.event_code;
      out_payload_handle <= pend.handle;
      slots_left         <= pend.slots;
      queue_count        <= count_now;
    end
  end

  // An add that finds room always leaves the head cell occupied.
  a_add_fills_head: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == ptq_pkg::REQ_ADD) && !full |=> valids[0])
    else $error("head cell empty after an accepted add");

  // Outside a purge the chain has no holes in front of valid entries.
  a_compact_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_COMPACT) |-> !busy)
    else $error("chain has a hole outside compaction");

  // A dispatch raises the active count by exactly one.
  a_dispatch_counts: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == ptq_pkg::REQ_START) && can_pop |=>
      (active_count == $past(active_count) + 4'd1))
    else $error("active count not raised by a dispatch");

  // A result appears only when a request has finished its work.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result presented without a finished request");

endmodule

>>> rtl/ptq_cell.sv
module ptq_cell (
  input  logic                clk,
  input  logic                rst,
  input  ptq_pkg::cell_ctrl_t ctrl,
  input  ptq_pkg::entry_t     left,
  input  logic                left_mark,
  input  ptq_pkg::entry_t     right,
  output ptq_pkg::entry_t     cur,
  output logic                mark,
  output logic                bubble
);

  logic            valid;
  logic            valid_next;
  ptq_pkg::entry_t data;
  ptq_pkg::entry_t data_next;
  logic            addr_match;

  // This cell stands at or behind the insert point of the request item.
  assign mark       = !valid || (data.prio > ctrl.item.prio);
  assign bubble     = !valid && right.valid;
  assign addr_match = (data.addr_hi == ctrl.item.addr_hi) &&
                      (data.addr_lo == ctrl.item.addr_lo);

  always_comb begin
    cur       = data;
    cur.valid = valid;
  end

  always_comb begin
    valid_next = valid;
    data_next  = data;
    case (ctrl.op)
      ptq_pkg::CELL_INSERT: begin
        if (mark) begin
          if (left_mark) begin
            valid_next = left.valid;
            data_next  = left;
          end else begin
            valid_next = 1'b1;
            data_next  = ctrl.item;
          end
        end
      end
      ptq_pkg::CELL_POP: begin
        valid_next = right.valid;
        data_next  = right;
      end
      ptq_pkg::CELL_PURGE: begin
        if (valid && addr_match) begin
          valid_next = 1'b0;
        end
      end
      ptq_pkg::CELL_COMPACT: begin
        // Holes move one cell toward the tail each cycle.
        if (bubble) begin
          valid_next = 1'b1;
          data_next  = right;
        end else if (valid && !left.valid) begin
          valid_next = 1'b0;
        end
      end
      default: begin
        valid_next = valid;
        data_next  = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> tb/tb_priority_transaction_queue.sv
`timescale 1ns / 1ps

// Testbench for the priority transaction queue.
//
// A short directed part walks through every request code, the field extremes
// and the corner cases of the queue: a start at the limit, a start on an
// empty queue, a finish with nothing running, a limit lowered below the
// running count, and purges that match on one address half only.
// Random traffic then runs in phases with different limits and request mixes.
// Some phases fill the queue until adds are refused, some drain it, and some
// are dominated by purges. Both the sender and the receiver insert idle gaps
// of random length, and some stretches run without any gaps.
//
// Every accepted transaction is fed to a behavioral model of the queue. The
// model keeps its own sorted entry list, running count and limit. The outcome
// it predicts is queued, and each result that the block delivers is compared
// field by field with the oldest queued outcome.
module tb_priority_transaction_queue;

  localparam int DEPTH       = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 400000;

  // One result of the block, as the model predicts it.
  typedef struct packed {
    logic             accepted;
    logic             dispatched;
    logic [7:0]       event_code;
    logic [15:0]      handle;
    logic [3:0]       slots;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic clk;
  logic rst = 1'b1;

  // Every block input starts at a known value.
  logic        cfg_valid      = 1'b0;
  logic [3:0]  cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic [1:0]  req_type       = ptq_pkg::REQ_ADD;
  logic [7:0]  event_code     = '0;
  logic [15:0] payload_handle = '0;
  logic [1:0]  priority_req   = '0;
  logic [63:0] node_addr_hi   = '0;
  logic [63:0] node_addr_lo   = '0;
  logic        out_stall      = 1'b0;

  logic             cfg_ready;
  logic             in_stall;
  logic             out_valid;
  logic             accepted;
  logic             dispatched;
  logic [7:0]       out_event_code;
  logic [15:0]      out_payload_handle;
  logic [3:0]       slots_left;
  logic [CNT_W-1:0] queue_count;

  // Model state: the waiting entries in queue order, the number of running
  // transactions and the current max_active setting.
  ptq_pkg::entry_t model_waiting[$];
  int unsigned     model_running;
  int unsigned     model_limit;

  // Outcomes predicted for accepted transactions whose results are still due.
  outcome_t pending_outcomes[$];

  int errors;
  int cycle_count;
  int stall_run;

  // When set, neither side inserts gaps.
  bit calm;

  // Node addresses that random traffic reuses so that purges find matches.
  logic [63:0] pool_hi[4];
  logic [63:0] pool_lo[4];

  priority_transaction_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .req_type          (req_type),
    .event_code        (event_code),
    .payload_handle    (payload_handle),
    .priority_req      (priority_req),
    .node_addr_hi      (node_addr_hi),
    .node_addr_lo      (node_addr_lo),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .accepted          (accepted),
    .dispatched        (dispatched),
    .out_event_code    (out_event_code),
    .out_payload_handle(out_payload_handle),
    .slots_left        (slots_left),
    .queue_count       (queue_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length for either side. Most gaps are empty or short, and a few are
  // long enough to let the other side pile up work.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (calm) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Applies one request to the model and returns the result it must cause.
  // An add slides in behind every entry of equal or more urgent priority, so
  // entries of one level keep their arrival order. A purge first retires one
  // running transaction and then drops every entry whose full 128-bit address
  // matches, keeping the order of the rest.
  function automatic outcome_t apply_request(input logic [1:0] req,
                                             input logic [7:0] ev,
                                             input logic [15:0] hd,
                                             input logic [1:0] pr,
                                             input logic [63:0] hi,
                                             input logic [63:0] lo);
    outcome_t        res;
    ptq_pkg::entry_t item;
    ptq_pkg::entry_t kept[$];
    int              pos;
    bit              was_empty;
    res = '0;
    case (req)
      ptq_pkg::REQ_ADD: begin
        if (model_waiting.size() < DEPTH) begin
          item            = '0;
          item.valid      = 1'b1;
          item.prio       = pr;
          item.event_code = ev;
          item.handle     = hd;
          item.addr_hi    = hi;
          item.addr_lo    = lo;
          pos = model_waiting.size();
          while (pos > 0 && model_waiting[pos-1].prio > pr) pos--;
          model_waiting.insert(pos, item);
          res.accepted = 1'b1;
        end
      end
      ptq_pkg::REQ_START: begin
        was_empty = 1'b0;
        if (model_running < model_limit) begin
          if (model_waiting.size() > 0) begin
            item = model_waiting.pop_front();
            res.dispatched = 1'b1;
            res.event_code = item.event_code;
            res.handle     = item.handle;
            model_running++;
          end else begin
            was_empty = 1'b1;
          end
        end
        // The slot count saturates at zero when the limit was lowered below
        // the number already running.
        if (!was_empty && model_limit > model_running)
          res.slots = 4'(model_limit - model_running);
      end
      ptq_pkg::REQ_FINISH, ptq_pkg::REQ_PURGE: begin
        if (model_running > 0) model_running--;
        if (req == ptq_pkg::REQ_PURGE) begin
          foreach (model_waiting[k])
            if (!(model_waiting[k].addr_hi == hi && model_waiting[k].addr_lo == lo))
              kept.push_back(model_waiting[k]);
          model_waiting = kept;
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(model_waiting.size());
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checking: every result taken by the receiver is matched against the
  // oldest predicted outcome.
  always @(posedge clk) begin : score_results
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: result with no transaction outstanding, expected none, actual %0d",
                 $time, queue_count);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted));
        check_field("dispatched", 32'(want.dispatched), 32'(dispatched));
        check_field("out_event_code", 32'(want.event_code), 32'(out_event_code));
        check_field("out_payload_handle", 32'(want.handle), 32'(out_payload_handle));
        check_field("slots_left", 32'(want.slots), 32'(slots_left));
        check_field("queue_count", 32'(want.count), 32'(queue_count));
      end
    end
  end

  // Receiver back-pressure: random stall runs, none while calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      stall_run = 0;
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      stall_run = ($urandom_range(3) == 0) ? pick_gap() : 0;
      out_stall <= 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sends one request transaction. The valid line is only lowered when a gap
  // comes first, so back-to-back transactions keep it high. The outcome is
  // predicted at the edge where the block takes the transaction.
  task automatic send_request(input logic [1:0] req, input logic [7:0] ev,
                              input logic [15:0] hd, input logic [1:0] pr,
                              input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= req;
    event_code     <= ev;
    payload_handle <= hd;
    priority_req   <= pr;
    node_addr_hi   <= hi;
    node_addr_lo   <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(apply_request(req, ev, hd, pr, hi, lo));
  endtask

  // Holds off the sender until every outstanding result has come back. At
  // least one edge passes, so the valid line is never lowered and raised in
  // the same step.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // The limit is only changed while the block is idle.
  task automatic write_max_active(input logic [3:0] limit);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_limit = 32'(limit);
    cfg_valid <= 1'b0;
  endtask

  // Every request code with the field extremes, starting from the reset
  // limit of one. Two entries share one address half with a third, so a
  // purge must compare the whole 128 bits.
  task automatic test_request_codes();
    send_request(ptq_pkg::REQ_ADD, 8'hFF, 16'hFFFF, 2'd3, '1, '1);
    send_request(ptq_pkg::REQ_ADD, 8'h00, 16'h0000, 2'd0, '0, '0);
    send_request(ptq_pkg::REQ_ADD, 8'h5A, 16'hA5C3, 2'd1, '0, '1);
    send_request(ptq_pkg::REQ_ADD, 8'h3C, 16'h1234, 2'd3, '1, '0);
    // The urgent entry leaves first, then the limit blocks a second start.
    send_request(ptq_pkg::REQ_START, '0, '0, '0, '0, '0);
    send_request(ptq_pkg::REQ_START, '1, '1, '1, '1, '1);
    // The second finish arrives with nothing running.
    send_request(ptq_pkg::REQ_FINISH, '0, '0, '0, '0, '0);
    send_request(ptq_pkg::REQ_FINISH, '1, '1, '1, '1, '1);
    send_request(ptq_pkg::REQ_START, '0, '0, '0, '0, '0);
    // Only the all-ones entry matches; the half matches stay.
    send_request(ptq_pkg::REQ_PURGE, '0, '0, '0, '1, '1);
    send_request(ptq_pkg::REQ_START, '0, '0, '0, '0, '0);
    send_request(ptq_pkg::REQ_PURGE, '0, '0, '0, '0, '1);
    // A start on the empty queue below the limit reports no slots.
    send_request(ptq_pkg::REQ_START, '0, '0, '0, '0, '0);
    send_request(ptq_pkg::REQ_FINISH, '0, '0, '0, '0, '0);
  endtask

  // Runs three transactions under the widest limit, then lowers the limit to
  // one so that the running count stands above it and the slot count must
  // saturate at zero.
  task automatic test_lowered_limit();
    logic [63:0] hi;
    logic [63:0] lo;
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    write_max_active(4'd15);
    repeat (4) send_request(ptq_pkg::REQ_ADD, 8'($urandom), 16'($urandom), 2'd2, hi, lo);
    repeat (3) send_request(ptq_pkg::REQ_START, '0, '0, '0, '0, '0);
    write_max_active(4'd1);
    send_request(ptq_pkg::REQ_START, '0, '0, '0, '0, '0);
    send_request(ptq_pkg::REQ_PURGE, '0, '0, '0, hi, lo);
  endtask

  // One phase of random traffic with the given request mix. The address pool
  // is refreshed per phase; two pool entries share one half with a third so
  // that half matches show up in purges. Halfway through, the sender waits
  // until every result is back.
  task automatic run_traffic(input int count, input int w_add, input int w_start,
                             input int w_finish, input int w_purge);
    int          roll;
    logic [1:0]  req;
    logic [63:0] hi;
    logic [63:0] lo;
    int          pick;
    foreach (pool_hi[k]) begin
      pool_hi[k] = {$urandom, $urandom};
      pool_lo[k] = {$urandom, $urandom};
    end
    pool_hi[1] = pool_hi[0];
    pool_lo[2] = pool_lo[0];
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      roll = $urandom_range(w_add + w_start + w_finish + w_purge - 1);
      if (roll < w_add) req = ptq_pkg::REQ_ADD;
      else if (roll < w_add + w_start) req = ptq_pkg::REQ_START;
      else if (roll < w_add + w_start + w_finish) req = ptq_pkg::REQ_FINISH;
      else req = ptq_pkg::REQ_PURGE;
      if ($urandom_range(9) < 8) begin
        pick = $urandom_range(3);
        hi = pool_hi[pick];
        lo = pool_lo[pick];
      end else begin
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
      end
      // Requests 85 to 99 of each hundred in a phase run with no gaps at all.
      calm = (i % 100) >= 85;
      send_request(req, 8'($urandom), 16'($urandom), 2'($urandom), hi, lo);
    end
    calm = 1'b0;
  endtask

  // Random phases over several limits, one and fifteen among them. Add-heavy
  // phases fill the queue until adds are refused; start-heavy phases empty it.
  task automatic test_traffic_mix();
    write_max_active(4'd1);
    run_traffic(100, 70, 15, 10, 5);
    write_max_active(4'd15);
    run_traffic(100, 40, 35, 15, 10);
    write_max_active(4'd4);
    calm = 1'b1;
    run_traffic(80, 35, 35, 20, 10);
    write_max_active(4'd2);
    run_traffic(100, 20, 45, 25, 10);
    write_max_active(4'd15);
    run_traffic(120, 75, 15, 5, 5);
    write_max_active(4'd7);
    run_traffic(100, 30, 25, 15, 30);
    write_max_active(4'd1);
    run_traffic(100, 40, 30, 20, 10);
    write_max_active(4'($urandom_range(15, 1)));
    run_traffic(100, 45, 30, 15, 10);
  endtask

  initial begin
    errors        = 0;
    cycle_count   = 0;
    calm          = 1'b0;
    model_running = 0;
    model_limit   = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_request_codes();
    test_lowered_limit();
    test_traffic_mix();

    // Wait for the last results, then give the block time to show any stray
    // result before the verdict.
    drain_results();
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/ptq_pkg.sv
rtl/ptq_cell.sv
rtl/priority_transaction_queue.sv
tb/tb_priority_transaction_queue.sv
